// ===== hdl/alarm_frame_parser_core_defines.svh =====
// Assertion macros shared by the alarm frame parser RTL.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef ALARM_FRAME_PARSER_CORE_DEFINES_SVH
`define ALARM_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alarm frame parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alarm frame parser check failed");

`endif

// ===== hdl/afp_pkg.sv =====
// Package for the alarm frame parser: frame kinds, header and tail bytes,
// the event word type and parameter defaults. Depends on nothing.
`timescale 1ns / 1ps

package afp_pkg;

  typedef enum logic [1:0] {
    KIND_ALARM = 2'd0,
    KIND_FAULT = 2'd1,
    KIND_RESET = 2'd2
  } kind_e;

  localparam logic [7:0] HDR_ALARM_FIRST  = 8'h0D;
  localparam logic [7:0] HDR_ALARM_SECOND = 8'hDD;
  localparam logic [7:0] HDR_FAULT_FIRST  = 8'h0E;
  localparam logic [7:0] HDR_FAULT_SECOND = 8'hEE;
  localparam logic [7:0] HDR_RESET_FIRST  = 8'h0A;
  localparam logic [7:0] HDR_RESET_SECOND = 8'hAA;
  localparam logic [7:0] TAIL_BYTE        = 8'hBB;
  localparam logic [7:0] ALARM_ID_MAX     = 8'h11;
  localparam logic [7:0] STATUS_ALARM     = 8'h01;
  localparam logic [7:0] STATUS_FAULT     = 8'h00;

  // Body bytes kept per frame: three ID bytes, the fourth ID byte, status.
  localparam int unsigned BODY_KEEP = 5;
  // Hunt count must reach three before a header is recognized.
  localparam int unsigned HUNT_MIN  = 3;

  localparam int unsigned FRAME_MAX_DEF = 64;
  localparam int unsigned REC_LIMIT_DEF = 256;

  // Register byte address of port_number.
  localparam logic [2:0] REG_PORT_ADDR = 3'd0;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  controller_id;
    logic [15:0] device_number;
    logic [15:0] loop_number;
    logic [7:0]  port;
  } event_t;

endpackage

// ===== hdl/alarm_frame_parser_core.sv =====
// Alarm frame parser top level: header hunt, frame body capture and event
// output with a two-word output buffer. Depends on afp_pkg and the defines
// header.
`timescale 1ns / 1ps
`include "alarm_frame_parser_core_defines.svh"

// The parser takes one received byte per clock cycle while in_stall_o is low
// and accepts bytes back to back. Each byte is processed by the single stage
// between the parser state registers and the output register; an accepted tail
// byte's event goes to the output register, or to the skid register if the output
// word is held. The output side holds two words; in_stall_o rises only when both
// are full, so a stalled consumer stalls no input until the second word is
// waiting. port_number is read and written over the APB port at address 0.
module alarm_frame_parser_core #(
  parameter int unsigned FrameMax = afp_pkg::FRAME_MAX_DEF,
  parameter int unsigned RecLimit = afp_pkg::REC_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Event output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  controller_id_o,
  output logic [15:0] device_number_o,
  output logic [15:0] loop_number_o,
  output logic [7:0]  port_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned HalfLimit = RecLimit / 2;
  localparam int unsigned HuntW     = $clog2(HalfLimit + 2);
  localparam int unsigned LenW      = $clog2(FrameMax);
  localparam int unsigned BodyKeep  = afp_pkg::BODY_KEEP;

  // Configuration register.
  logic [7:0] port_q;

  // Parser state.
  logic [7:0]            last_q, prev_q;
  logic [HuntW-1:0]      hunt_q, hunt_d;
  logic                  in_frame_q, in_frame_d;
  afp_pkg::kind_e        kind_q, kind_d;
  logic [7:0]            ctrl_q, ctrl_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [7:0]            body_q [BodyKeep];
  logic [BodyKeep-1:0]   body_we;
  logic [7:0]            body_v [BodyKeep];

  // Output buffer.
  logic                  ov_q, sv_q;
  afp_pkg::event_t       od_q, sd_q;

  logic                  accept, pop;
  logic                  emit;
  afp_pkg::event_t       ev;

  logic [HuntW:0]        hunt_inc;
  logic [LenW:0]         len_inc;
  logic                  hdr_hit, drop, long_enough, check_ok;
  afp_pkg::kind_e        hdr_kind;

  assign pready = 1'b1;
  assign prdata = (paddr == afp_pkg::REG_PORT_ADDR) ? {24'd0, port_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= 8'd0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == afp_pkg::REG_PORT_ADDR) begin
      port_q <= pwdata[7:0];
    end
  end

  assign in_stall_o = sv_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = ov_q && !out_stall_i;

  // Header decode on the previous byte and the incoming one.
  always_comb begin
    hdr_hit  = 1'b1;
    hdr_kind = afp_pkg::KIND_ALARM;
    if (last_q == afp_pkg::HDR_ALARM_FIRST && rx_byte_i == afp_pkg::HDR_ALARM_SECOND) begin
      hdr_kind = afp_pkg::KIND_ALARM;
    end else if (last_q == afp_pkg::HDR_FAULT_FIRST &&
                 rx_byte_i == afp_pkg::HDR_FAULT_SECOND) begin
      hdr_kind = afp_pkg::KIND_FAULT;
    end else if (last_q == afp_pkg::HDR_RESET_FIRST &&
                 rx_byte_i == afp_pkg::HDR_RESET_SECOND) begin
      hdr_kind = afp_pkg::KIND_RESET;
    end else begin
      hdr_hit = 1'b0;
    end
  end

  // Body capture: the byte at frame position i lands in entry i. The check
  // below uses the updated view so that a tail in position four is seen.
  for (genvar i = 0; i < BodyKeep; i++) begin : g_body
    assign body_we[i] = in_frame_q && (len_q == LenW'(i));
    assign body_v[i]  = body_we[i] ? rx_byte_i : body_q[i];

    always_ff @(posedge clk_i) begin
      if (accept && body_we[i]) begin
        body_q[i] <= rx_byte_i;
      end
    end
  end

  assign hunt_inc    = {1'b0, hunt_q} + (HuntW+1)'(1);
  assign len_inc     = {1'b0, len_q} + (LenW+1)'(1);
  assign drop        = len_inc >= (LenW+1)'(FrameMax - 2);
  assign long_enough = len_inc >= (LenW+1)'(BodyKeep);

  always_comb begin
    case (kind_q)
      afp_pkg::KIND_ALARM: check_ok = long_enough && (body_v[3] <= afp_pkg::ALARM_ID_MAX) &&
                                      (body_v[4] == afp_pkg::STATUS_ALARM);
      afp_pkg::KIND_FAULT: check_ok = long_enough && (body_v[4] == afp_pkg::STATUS_FAULT);
      afp_pkg::KIND_RESET: check_ok = 1'b1;
      default:             check_ok = 1'b0;
    endcase
  end

  always_comb begin
    hunt_d     = hunt_q;
    in_frame_d = in_frame_q;
    kind_d     = kind_q;
    ctrl_d     = ctrl_q;
    len_d      = len_q;
    emit       = 1'b0;
    if (!in_frame_q) begin
      hunt_d = hunt_inc[HuntW-1:0];
      if (hunt_inc >= (HuntW+1)'(afp_pkg::HUNT_MIN)) begin
        if (hdr_hit) begin
          in_frame_d = 1'b1;
          kind_d     = hdr_kind;
          ctrl_d     = prev_q;
          len_d      = '0;
        end else if (hunt_inc > (HuntW+1)'(HalfLimit)) begin
          hunt_d = '0;
        end
      end
    end else begin
      len_d = len_inc[LenW-1:0];
      if (drop) begin
        in_frame_d = 1'b0;
        len_d      = '0;
        hunt_d     = '0;
      end else if (rx_byte_i == afp_pkg::TAIL_BYTE) begin
        in_frame_d = 1'b0;
        hunt_d     = '0;
        emit       = check_ok;
      end
    end
  end

  // Reset frames and short frames report zero device and loop numbers.
  always_comb begin
    ev.kind          = kind_q;
    ev.controller_id = ctrl_q;
    ev.port          = port_q;
    if (kind_q != afp_pkg::KIND_RESET && long_enough) begin
      ev.device_number = {body_v[0], 8'd0};
      ev.loop_number   = {body_v[2], body_v[1]};
    end else begin
      ev.device_number = 16'd0;
      ev.loop_number   = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= 8'd0;
      prev_q     <= 8'd0;
      hunt_q     <= '0;
      in_frame_q <= 1'b0;
      kind_q     <= afp_pkg::KIND_ALARM;
      ctrl_q     <= 8'd0;
      len_q      <= '0;
    end else if (accept) begin
      last_q     <= rx_byte_i;
      prev_q     <= last_q;
      hunt_q     <= hunt_d;
      in_frame_q <= in_frame_d;
      kind_q     <= kind_d;
      ctrl_q     <= ctrl_d;
      len_q      <= len_d;
    end
  end

  // Output register with a skid word behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (pop) begin
        sv_q <= 1'b0;
      end
    end else if (ov_q && !pop) begin
      sv_q <= accept && emit;
    end else begin
      ov_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (pop) begin
        od_q <= sd_q;
      end
    end else if (ov_q && !pop) begin
      sd_q <= ev;
    end else begin
      od_q <= ev;
    end
  end

  assign out_valid_o     = ov_q;
  assign event_kind_o    = od_q.kind;
  assign controller_id_o = od_q.controller_id;
  assign device_number_o = od_q.device_number;
  assign loop_number_o   = od_q.loop_number;
  assign port_o          = od_q.port;

  `AFP_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, sv_q, ov_q)
  `AFP_ASSERT_NEXT(a_held_word_kept, clk_i, rst_ni, ov_q && out_stall_i, ov_q)
  `AFP_ASSERT_NOW(a_kind_legal, clk_i, rst_ni, ov_q, od_q.kind != 2'd3)
  `AFP_ASSERT_NOW(a_frame_len_bound, clk_i, rst_ni, in_frame_q,
                  {1'b0, len_q} < (LenW+1)'(FrameMax - 2))
  `AFP_ASSERT_NOW(a_hunt_bound, clk_i, rst_ni, !in_frame_q,
                  {1'b0, hunt_q} <= (HuntW+1)'(HalfLimit))

endmodule

// ===== test/alarm_frame_parser_core_tb.sv =====
// Self-checking testbench for alarm_frame_parser_core: byte stream stimulus, a
// cycle-free frame parser predictor and per-field event checking.
// Depends on afp_pkg and the alarm_frame_parser_core RTL.
`timescale 1ns / 1ps

module alarm_frame_parser_core_tb;

  localparam int unsigned FRAME_MAX     = afp_pkg::FRAME_MAX_DEF;
  localparam int unsigned REC_LIMIT     = afp_pkg::REC_LIMIT_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind_o;
  logic [7:0]  controller_id_o;
  logic [15:0] device_number_o;
  logic [15:0] loop_number_o;
  logic [7:0]  port_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Parser state mirrored by the predictor.
  logic [7:0]      port_cfg = 8'h00;
  logic [7:0]      last_b = 8'h00;
  logic [7:0]      prev_b = 8'h00;
  logic [15:0]     hunt_cnt = '0;
  bit              in_frame = 1'b0;
  afp_pkg::kind_e  fr_kind = afp_pkg::KIND_ALARM;
  logic [7:0]      fr_ctrl = 8'h00;
  logic [7:0]      fr_body [afp_pkg::BODY_KEEP];
  logic [6:0]      fr_len = '0;

  afp_pkg::event_t pending_events [$];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_until = 0;
  bit          idle_en = 1'b1;
  bit          stall_en = 1'b1;

  alarm_frame_parser_core #(
    .FrameMax(FRAME_MAX),
    .RecLimit(REC_LIMIT)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall_o),
    .rx_byte_i(rx_byte),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .event_kind_o(event_kind_o),
    .controller_id_o(controller_id_o),
    .device_number_o(device_number_o),
    .loop_number_o(loop_number_o),
    .port_o(port_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver stalls at random, and holds off completely until hold_until.
  always @(posedge clk_i) begin
    if (cycle_count < hold_until) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_en && ($urandom_range(99) < 16);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  function automatic bit header_match(input logic [7:0] first, input logic [7:0] second,
                                      output afp_pkg::kind_e k);
    k = afp_pkg::KIND_ALARM;
    if (first == afp_pkg::HDR_ALARM_FIRST && second == afp_pkg::HDR_ALARM_SECOND) begin
      k = afp_pkg::KIND_ALARM;
      return 1'b1;
    end
    if (first == afp_pkg::HDR_FAULT_FIRST && second == afp_pkg::HDR_FAULT_SECOND) begin
      k = afp_pkg::KIND_FAULT;
      return 1'b1;
    end
    if (first == afp_pkg::HDR_RESET_FIRST && second == afp_pkg::HDR_RESET_SECOND) begin
      k = afp_pkg::KIND_RESET;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the parser state by one word and queues the event it closes, if any.
  function automatic void parse_byte(input logic [7:0] b);
    logic [15:0]     cnt;
    afp_pkg::kind_e  k;
    int unsigned     len;
    bit              fire;
    afp_pkg::event_t ev;
    if (!in_frame) begin
      cnt = (hunt_cnt != 16'hFFFF) ? hunt_cnt + 16'd1 : hunt_cnt;
      if (cnt >= afp_pkg::HUNT_MIN) begin
        if (header_match(last_b, b, k)) begin
          in_frame = 1'b1;
          fr_kind  = k;
          fr_ctrl  = prev_b;
          fr_len   = '0;
        end else if (cnt > REC_LIMIT / 2) begin
          cnt = '0;
        end
      end
      hunt_cnt = cnt;
    end else begin
      if (fr_len < afp_pkg::BODY_KEEP) fr_body[fr_len[2:0]] = b;
      len = fr_len + 1;
      fr_len = len[6:0];
      if (len + 2 >= FRAME_MAX) begin
        in_frame = 1'b0;
        fr_len   = '0;
        hunt_cnt = '0;
      end else if (b == afp_pkg::TAIL_BYTE) begin
        in_frame = 1'b0;
        hunt_cnt = '0;
        fire = 1'b0;
        ev.kind          = fr_kind;
        ev.controller_id = fr_ctrl;
        ev.device_number = '0;
        ev.loop_number   = '0;
        ev.port          = port_cfg;
        if (fr_kind == afp_pkg::KIND_RESET) begin
          fire = 1'b1;
        end else if (len >= afp_pkg::BODY_KEEP) begin
          if (fr_kind == afp_pkg::KIND_ALARM) begin
            fire = (fr_body[3] <= afp_pkg::ALARM_ID_MAX) &&
                   (fr_body[4] == afp_pkg::STATUS_ALARM);
          end else begin
            fire = (fr_body[4] == afp_pkg::STATUS_FAULT);
          end
          ev.device_number = {fr_body[0], 8'h00};
          ev.loop_number   = {fr_body[2], fr_body[1]};
        end
        if (fire) pending_events.push_back(ev);
      end
    end
    prev_b = last_b;
    last_b = b;
  endfunction

  always @(posedge clk_i) begin : check_event
    afp_pkg::event_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event with none pending", {6'd0, event_kind_o, controller_id_o,
                        device_number_o}, '0);
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.kind)
          report_mismatch("event_kind", 32'(event_kind_o), 32'(want.kind));
        if (controller_id_o !== want.controller_id)
          report_mismatch("controller_id", 32'(controller_id_o), 32'(want.controller_id));
        if (device_number_o !== want.device_number)
          report_mismatch("device_number", 32'(device_number_o), 32'(want.device_number));
        if (loop_number_o !== want.loop_number)
          report_mismatch("loop_number", 32'(loop_number_o), 32'(want.loop_number));
        if (port_o !== want.port)
          report_mismatch("port", 32'(port_o), 32'(want.port));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_en && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(b);
    bytes_sent++;
  endtask

  // Stops sending, waits for every pending event, then lets the pipeline empty.
  task automatic wait_for_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= afp_pkg::REG_PORT_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_port(input logic [7:0] value);
    logic [31:0] rd;
    wait_for_events();
    apb_access(1'b1, {24'h0, value}, rd);
    port_cfg = value;
    apb_access(1'b0, '0, rd);
    if (rd[7:0] !== value)
      report_mismatch("port_number readback", 32'(rd[7:0]), 32'(value));
  endtask

  function automatic logic [7:0] body_noise();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == afp_pkg::TAIL_BYTE) v = 8'h00;
    return v;
  endfunction

  // Sends controller ID, header, body and (if with_tail) tail. The first five
  // body bytes come from first5, most significant byte first; the rest are random.
  task automatic send_frame(input afp_pkg::kind_e k, input logic [7:0] ctrl, input int nbody,
                            input logic [39:0] first5, input bit with_tail);
    logic [7:0] b;
    send_byte(ctrl);
    case (k)
      afp_pkg::KIND_ALARM: begin
        send_byte(afp_pkg::HDR_ALARM_FIRST);
        send_byte(afp_pkg::HDR_ALARM_SECOND);
      end
      afp_pkg::KIND_FAULT: begin
        send_byte(afp_pkg::HDR_FAULT_FIRST);
        send_byte(afp_pkg::HDR_FAULT_SECOND);
      end
      default: begin
        send_byte(afp_pkg::HDR_RESET_FIRST);
        send_byte(afp_pkg::HDR_RESET_SECOND);
      end
    endcase
    for (int i = 0; i < nbody; i++) begin
      if (i < afp_pkg::BODY_KEEP) b = first5[39 - 8 * i -: 8];
      else b = body_noise();
      send_byte(b);
    end
    if (with_tail) send_byte(afp_pkg::TAIL_BYTE);
  endtask

  task automatic test_register_reset();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[7:0] !== port_cfg)
      report_mismatch("port_number after reset", 32'(rd[7:0]), 32'(port_cfg));
  endtask

  task automatic test_frame_kinds();
    set_port(8'hFF);
    send_frame(afp_pkg::KIND_ALARM, 8'h00, 5,
               {8'h00, 8'h00, 8'h00, afp_pkg::ALARM_ID_MAX, afp_pkg::STATUS_ALARM}, 1'b1);
    send_frame(afp_pkg::KIND_ALARM, 8'hFF, 5,
               {8'hFF, 8'hFF, 8'hFF, 8'h00, afp_pkg::STATUS_ALARM}, 1'b1);
    // Fourth ID byte one above the alarm limit, then a wrong status byte.
    send_frame(afp_pkg::KIND_ALARM, 8'h31, 5,
               {8'h12, 8'h34, 8'h56, 8'h12, afp_pkg::STATUS_ALARM}, 1'b1);
    send_frame(afp_pkg::KIND_ALARM, 8'h32, 5, {8'h12, 8'h34, 8'h56, 8'h05, 8'h02}, 1'b1);
    send_frame(afp_pkg::KIND_FAULT, 8'h41, 5,
               {8'h12, 8'h34, 8'h56, 8'hFF, afp_pkg::STATUS_FAULT}, 1'b1);
    send_frame(afp_pkg::KIND_FAULT, 8'h42, 5,
               {8'h12, 8'h34, 8'h56, 8'h00, afp_pkg::STATUS_ALARM}, 1'b1);
    send_frame(afp_pkg::KIND_RESET, 8'h51, 0, '0, 1'b1);
    send_frame(afp_pkg::KIND_RESET, 8'h52, 5, {8'hAB, 8'hCD, 8'hEF, 8'h01, 8'h01}, 1'b1);
    // Alarm and fault frames too short to hold a status byte.
    send_frame(afp_pkg::KIND_ALARM, 8'h61, 3,
               {8'h01, 8'h02, 8'h03, 8'h04, afp_pkg::STATUS_ALARM}, 1'b1);
    send_frame(afp_pkg::KIND_FAULT, 8'h62, 4,
               {8'h01, 8'h02, 8'h03, 8'h04, afp_pkg::STATUS_FAULT}, 1'b1);
    send_frame(afp_pkg::KIND_ALARM, 8'h71, 9,
               {8'hA0, 8'hB1, 8'hC2, 8'h10, afp_pkg::STATUS_ALARM}, 1'b1);
  endtask

  task automatic test_header_timing();
    set_port(8'h3C);
    // A header right after a frame comes before three words are counted.
    send_frame(afp_pkg::KIND_RESET, 8'h11, 0, '0, 1'b1);
    send_byte(afp_pkg::HDR_ALARM_FIRST);
    send_byte(afp_pkg::HDR_ALARM_SECOND);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(afp_pkg::TAIL_BYTE);
    // The hunt count clears on the word after the half limit and hides a header.
    send_frame(afp_pkg::KIND_RESET, 8'h53, 0, '0, 1'b1);
    repeat (REC_LIMIT / 2) send_byte(8'h55);
    send_byte(afp_pkg::HDR_FAULT_FIRST);
    send_byte(afp_pkg::HDR_FAULT_SECOND);
    send_frame(afp_pkg::KIND_FAULT, 8'h44, 5,
               {8'h10, 8'h20, 8'h30, 8'h40, afp_pkg::STATUS_FAULT}, 1'b1);
  endtask

  task automatic test_frame_overflow();
    set_port(8'hC3);
    send_frame(afp_pkg::KIND_ALARM, 8'h81, FRAME_MAX - 4,
               {8'h01, 8'h02, 8'h03, 8'h04, afp_pkg::STATUS_ALARM}, 1'b1);
    send_frame(afp_pkg::KIND_FAULT, 8'h82, FRAME_MAX - 3,
               {8'h01, 8'h02, 8'h03, 8'h04, afp_pkg::STATUS_FAULT}, 1'b1);
    send_frame(afp_pkg::KIND_RESET, 8'h83, FRAME_MAX - 3, '0, 1'b1);
    send_frame(afp_pkg::KIND_RESET, 8'h84, FRAME_MAX + 6, '0, 1'b1);
    send_frame(afp_pkg::KIND_RESET, 8'h85, 1, {8'h77, 32'h0}, 1'b1);
  endtask

  // The receiver holds off while reset frames keep coming, so the output words
  // fill and the input stalls; then the sender waits for every event.
  task automatic test_output_hold();
    set_port(8'h96);
    hold_until = cycle_count + HOLD_CYCLES;
    repeat (12) send_frame(afp_pkg::KIND_RESET, 8'($urandom), 0, '0, 1'b1);
    wait_for_events();
  endtask

  task automatic random_frame();
    afp_pkg::kind_e k;
    int             nbody;
    logic [39:0]    f5;
    k = afp_pkg::kind_e'($urandom_range(2));
    nbody = ($urandom_range(9) == 0) ? $urandom_range(9, FRAME_MAX + 2) : $urandom_range(8);
    f5 = {body_noise(), body_noise(), body_noise(), body_noise(), body_noise()};
    if ($urandom_range(4) != 0) begin
      if (k == afp_pkg::KIND_ALARM) begin
        f5[15:8] = 8'($urandom_range(afp_pkg::ALARM_ID_MAX));
        f5[7:0]  = afp_pkg::STATUS_ALARM;
      end else if (k == afp_pkg::KIND_FAULT) begin
        f5[7:0] = afp_pkg::STATUS_FAULT;
      end
    end
    send_frame(k, 8'($urandom), nbody, f5, $urandom_range(9) != 0);
  endtask

  task automatic test_random_traffic(input logic [7:0] port_value, input int count,
                                     input bit quiet);
    int target;
    set_port(port_value);
    idle_en  = !quiet;
    stall_en = !quiet;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if ($urandom_range(99) < 80) begin
        random_frame();
      end else begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      end
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_register_reset();
    test_frame_kinds();
    test_header_timing();
    test_frame_overflow();
    test_output_hold();
    test_random_traffic(8'h00, 250, 1'b0);
    test_random_traffic(8'hFF, 220, 1'b1);
    test_random_traffic(8'($urandom), 300, 1'b0);
    wait_for_events();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
